FILE: hw/rtl/first_fit_coalescing_allocator_assert.svh
// assertion macros for the first-fit allocator
// included by the allocator rtl file, which checks its own logic
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFA_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define FFA_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define FFA_ASSERT_IMP(label, clk, rst, a, c, msg)
`define FFA_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

FILE: hw/rtl/ffca_pkg.sv
// shared types and codes for the first-fit allocator
// no dependencies
package ffca_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [StatusW-1:0] StOk = 3'd0;
  localparam logic [StatusW-1:0] StZero = 3'd1;
  localparam logic [StatusW-1:0] StNoFit = 3'd2;
  localparam logic [StatusW-1:0] StBadRel = 3'd3;
  localparam logic [StatusW-1:0] StFull = 3'd4;

  localparam logic [CfgIdxW-1:0] RegABase = 3'd0;
  localparam logic [CfgIdxW-1:0] RegASize = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBBase = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBSize = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDBase = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDSize = 3'd5;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef enum logic [3:0] {
    S_REBUILD_A,
    S_REBUILD_B,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_SLOT,
    S_ALLOC_COMMIT,
    S_SHIFT_DOWN,
    S_REL_FIND,
    S_REL_POS,
    S_REL_MERGE,
    S_SHIFT_UP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [WordW-1:0] granted_address;
    logic [StatusW-1:0] status;
    logic [WordW-1:0] free_bytes;
    logic [WordW-1:0] min_free_bytes;
  } res_t;

  typedef struct packed {
    logic cmd;
    logic [WordW-1:0] request_bytes;
    logic dma_only;
    logic [WordW-1:0] release_address;
  } req_t;
endpackage

FILE: hw/rtl/ffca_if.sv
// valid/ready channel carrying one payload beat
// depends on nothing but the payload type given as a parameter
interface ffca_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/first_fit_coalescing_allocator.sv
// Heap allocator with first-fit search and coalescing of released blocks.
// Uses ffca_pkg, ffca_if and the assertion header.
//
// Usage: requests arrive on req (cmd, request_bytes, dma_only, release_address)
// and one result per request leaves on res (granted_address, status,
// free_bytes, min_free_bytes). Both are valid/ready channels; a beat moves
// when valid and ready are high at a rising edge.
// One request is in work at a time: req.ready is high only when the
// sequencer is idle and the result register is empty. A single comparator
// path walks the tables one entry per cycle. Allocate finishes at once
// for a rejected size, else runs scan, slot search, commit and a table
// shift if needed; release finishes at once for address zero, else runs
// slot search, position scan, merge and a table shift if needed.
// The next request is taken at the earliest in the cycle after the result
// beat has gone. The result waits in its register while res.ready is low;
// no new request is taken until it has gone. ALIGN_BYTES must be a power
// of two; the block itself does not check it.
// Reset (rst, synchronous) and any cfg write to a known register index
// rebuild the free table from the region registers in the states
// S_REBUILD_A and S_REBUILD_B and forget every granted block.
`include "first_fit_coalescing_allocator_assert.svh"
module first_fit_coalescing_allocator #(
  parameter int unsigned FREE_SEGMENTS = 16,
  parameter int unsigned USED_BLOCKS = 16,
  parameter int unsigned ALIGN_BYTES = 8,
  parameter int unsigned HEADER_BYTES = 8
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [ffca_pkg::CfgIdxW-1:0] cfg_index,
  input logic [ffca_pkg::WordW-1:0] cfg_data,
  ffca_if.sink req,
  ffca_if.source res
);
  localparam int unsigned FsW = (FREE_SEGMENTS > 1) ? $clog2(FREE_SEGMENTS) : 1;
  localparam int unsigned UbW = (USED_BLOCKS > 1) ? $clog2(USED_BLOCKS) : 1;
  localparam int unsigned FcW = $clog2(FREE_SEGMENTS + 1);
  localparam int unsigned UcW = $clog2(USED_BLOCKS + 1);
  localparam int unsigned W = ffca_pkg::WordW;
  localparam logic [W:0] AlignM = (W+1)'(ALIGN_BYTES);
  localparam logic [W:0] AlignMask = ~(AlignM - (W+1)'(1));
  localparam logic [W:0] Hdr = (W+1)'(HEADER_BYTES);
  localparam logic [W:0] Lim = {1'b1, {W{1'b0}}};

  logic [W-1:0] a_base, a_size, b_base, b_size, d_base, d_size;
  logic [W-1:0] seg_start [FREE_SEGMENTS];
  logic [W-1:0] seg_size [FREE_SEGMENTS];
  logic [FcW-1:0] seg_count;
  logic [W-1:0] blk_addr [USED_BLOCKS];
  logic [W-1:0] blk_size [USED_BLOCKS];
  logic [USED_BLOCKS-1:0] blk_valid;
  logic [W-1:0] free_total, low_mark;
  logic [W:0] last_mark;
  logic have_a;

  ffca_pkg::state_t state, state_next;
  ffca_pkg::req_t cur;
  logic [FcW-1:0] idx;
  logic [UcW-1:0] uidx;
  logic [W:0] want;
  logic [FsW-1:0] seg;
  logic [UbW-1:0] slot;
  logic [W-1:0] bsize;
  logic [FcW-1:0] shift_end;
  logic res_valid;
  ffca_pkg::res_t res_q;

  // region to segment arithmetic, shared by both rebuild states
  logic [W-1:0] rg_base, rg_size;
  logic [W:0] rg_start, rg_end, rg_mark;
  logic rg_ok;
  always_comb begin
    rg_base = (state == ffca_pkg::S_REBUILD_A) ? a_base : b_base;
    rg_size = (state == ffca_pkg::S_REBUILD_A) ? a_size : b_size;
    rg_start = ({1'b0, rg_base} + AlignM - 1'b1) & AlignMask;
    rg_end = {1'b0, rg_base} + {1'b0, rg_size};
    if (rg_end > Lim) rg_end = Lim;
    rg_mark = (rg_end - Hdr) & AlignMask;
    rg_ok = (rg_size != '0) && (rg_end >= Hdr) && (rg_mark > rg_start);
    if (state == ffca_pkg::S_REBUILD_B && have_a && rg_start <= last_mark) rg_ok = 1'b0;
  end

  // shared compare path
  logic [FsW-1:0] fi;
  logic [UbW-1:0] ui;
  logic [W:0] lo, hi;
  logic seg_fit;
  logic [W-1:0] bstart;
  logic left, right;
  logic [W:0] want_raw;
  always_comb begin
    fi = idx[FsW-1:0];
    ui = uidx[UbW-1:0];
    lo = cur.dma_only ? {1'b0, d_base} : '0;
    hi = cur.dma_only ? ({1'b0, d_base} + {1'b0, d_size}) : {1'b0, {W{1'b1}}};
    want_raw = ({1'b0, cur.request_bytes} + Hdr + AlignM - 1'b1) & AlignMask;
    seg_fit = ({1'b0, seg_start[fi]} >= lo) && ({1'b0, seg_start[fi]} < hi) &&
              ({1'b0, seg_size[fi]} >= want_raw);
    bstart = cur.release_address - W'(HEADER_BYTES);
    left = (idx != '0) &&
           ({1'b0, seg_start[FsW'(idx - 1'b1)]} + {1'b0, seg_size[FsW'(idx - 1'b1)]}
            == {1'b0, bstart});
    right = (idx < seg_count) && ({1'b0, bstart} + {1'b0, bsize} == {1'b0, seg_start[fi]});
  end

  always_comb begin
    state_next = state;
    case (state)
      ffca_pkg::S_REBUILD_A: state_next = ffca_pkg::S_REBUILD_B;
      ffca_pkg::S_REBUILD_B: state_next = ffca_pkg::S_IDLE;
      ffca_pkg::S_IDLE:
        if (req.valid && req.ready)
          state_next = (req.payload.cmd == ffca_pkg::CmdAlloc) ? ffca_pkg::S_ALLOC_SCAN
                                                               : ffca_pkg::S_REL_FIND;
      ffca_pkg::S_ALLOC_SCAN:
        if (cur.request_bytes == '0 || cur.request_bytes[W-1] || want_raw > {1'b0, free_total}
            || idx >= seg_count) state_next = ffca_pkg::S_DONE;
        else if (seg_fit) state_next = ffca_pkg::S_ALLOC_SLOT;
      ffca_pkg::S_ALLOC_SLOT:
        if (uidx >= UcW'(USED_BLOCKS)) state_next = ffca_pkg::S_DONE;
        else if (!blk_valid[ui]) state_next = ffca_pkg::S_ALLOC_COMMIT;
      ffca_pkg::S_ALLOC_COMMIT:
        state_next = ({1'b0, seg_size[seg]} - want > 2 * Hdr) ? ffca_pkg::S_DONE
                                                              : ffca_pkg::S_SHIFT_DOWN;
      ffca_pkg::S_SHIFT_DOWN:
        if (idx + 1'b1 >= shift_end) state_next = ffca_pkg::S_DONE;
      ffca_pkg::S_REL_FIND:
        if (cur.release_address == '0 || uidx >= UcW'(USED_BLOCKS))
          state_next = ffca_pkg::S_DONE;
        else if (blk_valid[ui] && blk_addr[ui] == cur.release_address)
          state_next = ffca_pkg::S_REL_POS;
      ffca_pkg::S_REL_POS:
        if (!(idx < seg_count && seg_start[fi] < bstart)) state_next = ffca_pkg::S_REL_MERGE;
      ffca_pkg::S_REL_MERGE:
        if (left && right) state_next = ffca_pkg::S_SHIFT_DOWN;
        else if (left || right || seg_count >= FcW'(FREE_SEGMENTS)) state_next = ffca_pkg::S_DONE;
        else state_next = ffca_pkg::S_SHIFT_UP;
      ffca_pkg::S_SHIFT_UP:
        if (idx == shift_end) state_next = ffca_pkg::S_DONE;
      ffca_pkg::S_DONE: state_next = ffca_pkg::S_IDLE;
      default: state_next = ffca_pkg::S_IDLE;
    endcase
    // writes to unknown register indexes leave the heap alone
    if (cfg_we && cfg_index <= ffca_pkg::RegDSize) state_next = ffca_pkg::S_REBUILD_A;
  end

  always_comb begin
    req.ready = (state == ffca_pkg::S_IDLE) && !res_valid && !cfg_we;
    res.valid = res_valid;
    res.payload = res_q;
  end

  logic [ffca_pkg::StatusW-1:0] st;
  logic split;
  logic [W-1:0] ftot_new;

  always_comb begin
    split = ({1'b0, seg_size[seg]} - want) > 2 * Hdr;
    ftot_new = free_total - (split ? want[W-1:0] : seg_size[seg]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffca_pkg::S_REBUILD_A;
      res_valid <= 1'b0;
      a_base <= '0; a_size <= '0; b_base <= '0; b_size <= '0;
      d_base <= '0; d_size <= '0;
      seg_count <= '0;
      blk_valid <= '0;
      free_total <= '0;
      low_mark <= '0;
      have_a <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) res_valid <= 1'b0;
      case (state)
        ffca_pkg::S_REBUILD_A: begin
          blk_valid <= '0;
          have_a <= rg_ok;
          if (rg_ok) begin
            seg_start[0] <= rg_start[W-1:0];
            seg_size[0] <= W'(rg_mark - rg_start);
            seg_count <= FcW'(1);
            free_total <= W'(rg_mark - rg_start);
            last_mark <= rg_mark;
          end else begin
            seg_count <= '0;
            free_total <= '0;
          end
        end
        ffca_pkg::S_REBUILD_B: begin
          if (rg_ok) begin
            seg_start[FsW'(seg_count)] <= rg_start[W-1:0];
            seg_size[FsW'(seg_count)] <= W'(rg_mark - rg_start);
            seg_count <= seg_count + 1'b1;
            free_total <= free_total + W'(rg_mark - rg_start);
            low_mark <= free_total + W'(rg_mark - rg_start);
          end else begin
            low_mark <= free_total;
          end
        end
        ffca_pkg::S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.payload;
            idx <= '0;
            uidx <= '0;
            st <= ffca_pkg::StOk;
          end
        end
        ffca_pkg::S_ALLOC_SCAN: begin
          want <= want_raw;
          if (cur.request_bytes == '0) st <= ffca_pkg::StZero;
          else if (cur.request_bytes[W-1] || want_raw > {1'b0, free_total} || idx >= seg_count)
            st <= ffca_pkg::StNoFit;
          else if (seg_fit) seg <= fi;
          else idx <= idx + 1'b1;
        end
        ffca_pkg::S_ALLOC_SLOT: begin
          if (uidx >= UcW'(USED_BLOCKS)) st <= ffca_pkg::StFull;
          else if (!blk_valid[ui]) slot <= ui;
          else uidx <= uidx + 1'b1;
        end
        ffca_pkg::S_ALLOC_COMMIT: begin
          blk_addr[slot] <= seg_start[seg] + W'(HEADER_BYTES);
          blk_valid[slot] <= 1'b1;
          if (split) begin
            blk_size[slot] <= want[W-1:0];
            seg_start[seg] <= seg_start[seg] + want[W-1:0];
            seg_size[seg] <= seg_size[seg] - want[W-1:0];
          end else begin
            blk_size[slot] <= seg_size[seg];
            idx <= FcW'(seg);
            shift_end <= seg_count;
          end
          free_total <= ftot_new;
          if (ftot_new < low_mark) low_mark <= ftot_new;
        end
        ffca_pkg::S_SHIFT_DOWN: begin
          if (idx + 1'b1 < shift_end) begin
            seg_start[fi] <= seg_start[FsW'(idx + 1'b1)];
            seg_size[fi] <= seg_size[FsW'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end else begin
            seg_count <= seg_count - 1'b1;
          end
        end
        ffca_pkg::S_REL_FIND: begin
          if (cur.release_address == '0) st <= ffca_pkg::StOk;
          else if (uidx >= UcW'(USED_BLOCKS)) st <= ffca_pkg::StBadRel;
          else if (blk_valid[ui] && blk_addr[ui] == cur.release_address) begin
            slot <= ui;
            bsize <= blk_size[ui];
          end else uidx <= uidx + 1'b1;
        end
        ffca_pkg::S_REL_POS: begin
          if (idx < seg_count && seg_start[fi] < bstart) idx <= idx + 1'b1;
        end
        ffca_pkg::S_REL_MERGE: begin
          if (left && right) begin
            seg_size[FsW'(idx - 1'b1)] <= seg_size[FsW'(idx - 1'b1)] + bsize + seg_size[fi];
            shift_end <= seg_count;
          end else if (left) begin
            seg_size[FsW'(idx - 1'b1)] <= seg_size[FsW'(idx - 1'b1)] + bsize;
          end else if (right) begin
            seg_start[fi] <= bstart;
            seg_size[fi] <= seg_size[fi] + bsize;
          end else if (seg_count >= FcW'(FREE_SEGMENTS)) begin
            st <= ffca_pkg::StFull;
          end else begin
            shift_end <= idx;
            idx <= seg_count;
          end
          if (left || right || seg_count < FcW'(FREE_SEGMENTS)) begin
            blk_valid[slot] <= 1'b0;
            free_total <= free_total + bsize;
          end
        end
        ffca_pkg::S_SHIFT_UP: begin
          if (idx == shift_end) begin
            seg_start[fi] <= bstart;
            seg_size[fi] <= bsize;
            seg_count <= seg_count + 1'b1;
          end else begin
            seg_start[fi] <= seg_start[FsW'(idx - 1'b1)];
            seg_size[fi] <= seg_size[FsW'(idx - 1'b1)];
            idx <= idx - 1'b1;
          end
        end
        ffca_pkg::S_DONE: begin
          res_valid <= 1'b1;
          res_q.granted_address <= (cur.cmd == ffca_pkg::CmdAlloc && st == ffca_pkg::StOk)
                                   ? blk_addr[slot] : '0;
          res_q.status <= st;
          res_q.free_bytes <= free_total;
          res_q.min_free_bytes <= low_mark;
        end
        default: ;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          ffca_pkg::RegABase: a_base <= cfg_data;
          ffca_pkg::RegASize: a_size <= cfg_data;
          ffca_pkg::RegBBase: b_base <= cfg_data;
          ffca_pkg::RegBSize: b_size <= cfg_data;
          ffca_pkg::RegDBase: d_base <= cfg_data;
          ffca_pkg::RegDSize: d_size <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  `FFA_ASSERT_IMP(a_ready_idle, clk, rst, req.ready, state == ffca_pkg::S_IDLE && !res_valid, "ready outside idle")
  `FFA_ASSERT_IMP(a_count_max, clk, rst, 1'b1, seg_count <= FcW'(FREE_SEGMENTS), "segment count overflow")
  `FFA_ASSERT_IMP(a_low_mark, clk, rst, state == ffca_pkg::S_IDLE, low_mark <= free_total, "low mark above free total")
  `FFA_ASSERT_NXT(a_done_res, clk, rst, state == ffca_pkg::S_DONE && !cfg_we, res_valid, "result lost")
endmodule

FILE: test/first_fit_coalescing_allocator_tb.sv
// self-checking testbench for the first-fit coalescing heap allocator
// depends on ffca_pkg, ffca_if and first_fit_coalescing_allocator from the rtl
`timescale 1ns / 100ps

class heap_scoreboard;
  logic [ffca_pkg::WordW-1:0] regs [6];
  logic [ffca_pkg::WordW-1:0] seg_start [16];
  logic [ffca_pkg::WordW-1:0] seg_size [16];
  int unsigned seg_cnt;
  logic [ffca_pkg::WordW-1:0] blk_addr [16];
  logic [ffca_pkg::WordW-1:0] blk_size [16];
  bit blk_live [16];
  logic [ffca_pkg::WordW-1:0] total;
  logic [ffca_pkg::WordW-1:0] low;
  ffca_pkg::res_t expected_q [$];
  logic [ffca_pkg::WordW-1:0] granted [$];
  int errors;
  int checked;
  int status_seen [5];

  function new();
    foreach (regs[i]) regs[i] = '0;
    rebuild();
  endfunction

  function bit add_region(logic [31:0] base, logic [31:0] size,
                          inout longint unsigned last, input bit have);
    longint unsigned s, e, m;
    if (size == 0) return 0;
    s = base;
    if (s % 8 != 0) s += 8 - s % 8;
    e = longint'(base) + size;
    if (e > 64'h1_0000_0000) e = 64'h1_0000_0000;
    if (e < 8) return 0;
    m = e - 8;
    m -= m % 8;
    if (m <= s) return 0;
    if (have && s <= last) return 0;
    if (seg_cnt >= 16) return 0;
    seg_start[seg_cnt] = s[31:0];
    seg_size[seg_cnt] = m[31:0] - s[31:0];
    seg_cnt++;
    total += m[31:0] - s[31:0];
    last = m;
    return 1;
  endfunction

  function void rebuild();
    longint unsigned mark;
    bit have;
    mark = 0;
    seg_cnt = 0;
    total = 0;
    foreach (seg_start[i]) begin
      seg_start[i] = 0;
      seg_size[i] = 0;
    end
    foreach (blk_live[i]) begin
      blk_addr[i] = 0;
      blk_size[i] = 0;
      blk_live[i] = 0;
    end
    granted.delete();
    have = add_region(regs[ffca_pkg::RegABase], regs[ffca_pkg::RegASize], mark, 0);
    void'(add_region(regs[ffca_pkg::RegBBase], regs[ffca_pkg::RegBSize], mark, have));
    low = total;
  endfunction

  function void write_reg(logic [ffca_pkg::CfgIdxW-1:0] idx, logic [ffca_pkg::WordW-1:0] val);
    regs[idx] = val;
    rebuild();
  endfunction

  function void drop_seg(int unsigned p);
    for (int unsigned i = p; i + 1 < seg_cnt; i++) begin
      seg_start[i] = seg_start[i+1];
      seg_size[i] = seg_size[i+1];
    end
    seg_cnt--;
  endfunction

  function logic [ffca_pkg::StatusW-1:0] allocate(logic [31:0] req, bit dma,
                                                  output logic [31:0] addr);
    longint unsigned want, lo, hi;
    int seg, slot;
    logic [31:0] bsize;
    addr = 0;
    if (req == 0) return ffca_pkg::StZero;
    if (req[31]) return ffca_pkg::StNoFit;
    want = longint'(req) + 8;
    if (want % 8 != 0) want += 8 - want % 8;
    if (want > total) return ffca_pkg::StNoFit;
    if (dma) begin
      lo = regs[ffca_pkg::RegDBase];
      hi = longint'(regs[ffca_pkg::RegDBase]) + regs[ffca_pkg::RegDSize];
    end else begin
      lo = 0;
      hi = 64'hffff_ffff;
    end
    seg = -1;
    for (int i = 0; i < seg_cnt; i++)
      if (seg_start[i] >= lo && seg_start[i] < hi && seg_size[i] >= want) begin
        seg = i;
        break;
      end
    if (seg < 0) return ffca_pkg::StNoFit;
    slot = -1;
    for (int i = 0; i < 16; i++)
      if (!blk_live[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return ffca_pkg::StFull;
    addr = seg_start[seg] + 8;
    if (longint'(seg_size[seg]) - want > 16) begin
      bsize = want[31:0];
      seg_start[seg] += bsize;
      seg_size[seg] -= bsize;
    end else begin
      bsize = seg_size[seg];
      drop_seg(seg);
    end
    blk_addr[slot] = addr;
    blk_size[slot] = bsize;
    blk_live[slot] = 1;
    total -= bsize;
    if (total < low) low = total;
    return ffca_pkg::StOk;
  endfunction

  function logic [ffca_pkg::StatusW-1:0] release_block(logic [31:0] addr);
    int slot;
    int unsigned p;
    logic [31:0] bstart, bsize;
    bit left, right;
    if (addr == 0) return ffca_pkg::StOk;
    slot = -1;
    for (int i = 0; i < 16; i++)
      if (blk_live[i] && blk_addr[i] == addr) begin
        slot = i;
        break;
      end
    if (slot < 0) return ffca_pkg::StBadRel;
    bstart = addr - 8;
    bsize = blk_size[slot];
    p = 0;
    while (p < seg_cnt && seg_start[p] < bstart) p++;
    left = p > 0 && longint'(seg_start[p-1]) + seg_size[p-1] == bstart;
    right = p < seg_cnt && longint'(bstart) + bsize == seg_start[p];
    if (left && right) begin
      seg_size[p-1] += bsize + seg_size[p];
      drop_seg(p);
    end else if (left) begin
      seg_size[p-1] += bsize;
    end else if (right) begin
      seg_start[p] = bstart;
      seg_size[p] += bsize;
    end else begin
      if (seg_cnt >= 16) return ffca_pkg::StFull;
      for (int unsigned i = seg_cnt; i > p; i--) begin
        seg_start[i] = seg_start[i-1];
        seg_size[i] = seg_size[i-1];
      end
      seg_start[p] = bstart;
      seg_size[p] = bsize;
      seg_cnt++;
    end
    blk_live[slot] = 0;
    total += bsize;
    foreach (granted[i])
      if (granted[i] == addr) begin
        granted.delete(i);
        break;
      end
    return ffca_pkg::StOk;
  endfunction

  function void note_request(ffca_pkg::req_t r);
    ffca_pkg::res_t e;
    logic [31:0] addr;
    if (r.cmd == ffca_pkg::CmdAlloc) begin
      e.status = allocate(r.request_bytes, r.dma_only, addr);
      if (e.status == ffca_pkg::StOk) granted.push_back(addr);
    end else begin
      e.status = release_block(r.release_address);
      addr = 0;
    end
    e.granted_address = (e.status == ffca_pkg::StOk) ? addr : '0;
    e.free_bytes = total;
    e.min_free_bytes = low;
    status_seen[e.status]++;
    expected_q.push_back(e);
  endfunction

  function void check_result(ffca_pkg::res_t a);
    ffca_pkg::res_t e;
    checked++;
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (a.granted_address !== e.granted_address) begin
      $error("granted_address expected %h actual %h", e.granted_address, a.granted_address);
      errors++;
    end
    if (a.status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, a.status);
      errors++;
    end
    if (a.free_bytes !== e.free_bytes) begin
      $error("free_bytes expected %h actual %h", e.free_bytes, a.free_bytes);
      errors++;
    end
    if (a.min_free_bytes !== e.min_free_bytes) begin
      $error("min_free_bytes expected %h actual %h", e.min_free_bytes, a.min_free_bytes);
      errors++;
    end
  endfunction
endclass

module first_fit_coalescing_allocator_tb;
  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [ffca_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [ffca_pkg::WordW-1:0] cfg_data = '0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  longint cycles = 0;
  heap_scoreboard sb = new();

  ffca_if #(.payload_t(ffca_pkg::req_t)) req_if (clk);
  ffca_if #(.payload_t(ffca_pkg::res_t)) res_if (clk);

  first_fit_coalescing_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_if), .res(res_if)
  );

  initial begin
    req_if.valid = 0;
    req_if.payload = '0;
    res_if.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (res_if.valid && res_if.ready) sb.check_result(res_if.payload);
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send(ffca_pkg::req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 0;
      @(posedge clk);
    end
    req_if.valid <= 1;
    req_if.payload <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send_alloc(logic [31:0] n, bit dma);
    ffca_pkg::req_t r;
    r.cmd = ffca_pkg::CmdAlloc;
    r.request_bytes = n;
    r.dma_only = dma;
    r.release_address = $urandom();
    send(r);
  endtask

  task automatic send_release(logic [31:0] a);
    ffca_pkg::req_t r;
    r.cmd = ffca_pkg::CmdRelease;
    r.request_bytes = $urandom();
    r.dma_only = $urandom_range(1);
    r.release_address = a;
    send(r);
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic program_heap(logic [31:0] ab, as, bb, bs, db, ds);
    logic [31:0] v [6];
    v = '{ab, as, bb, bs, db, ds};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_index <= ffca_pkg::CfgIdxW'(i);
      cfg_data <= v[i];
      sb.write_reg(ffca_pkg::CfgIdxW'(i), v[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  task automatic random_items(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 3) send_alloc(0, $urandom_range(1));
      else if (k < 8) send_alloc($urandom(), $urandom_range(1));
      else if (k < 55) send_alloc($urandom_range(1, 120), $urandom_range(1));
      else if (k < 92 && sb.granted.size() != 0)
        send_release(sb.granted[$urandom_range(sb.granted.size() - 1)]);
      else if (k < 96) send_release($urandom());
      else send_release(0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty heap, then unaligned base with window on region b
    send_alloc(16, 0);
    send_release(32'h0000_1008);
    program_heap(32'h1003, 32'h600, 32'h8000, 32'h400, 32'h8000, 32'h400);
    send_alloc(0, 0);
    send_alloc(32'h8000_0000, 0);
    send_alloc(32'hffff_ffff, 1);
    send_alloc(32'h7fff_ffff, 0);
    send_alloc(1, 0);
    send_alloc(24, 0);
    send_alloc(40, 0);
    send_alloc(8, 1);
    send_alloc(32'h600, 1);
    send_alloc(32'h3e0, 0);
    send_release(0);
    send_release(32'h1234_5677);
    for (int i = 0; i < 4 && sb.granted.size() != 0; i++) send_release(sb.granted[0]);
    for (int i = 0; i < 18; i++) send_alloc(8, i[0]);
    drain();
    // no idling, with a long receiver hold-off
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_req = 1;
    random_items(450);
    program_heap(32'h100, 32'h300, 32'hffff_fc00, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    src_idle_pct = 86;
    random_items(350);
    program_heap(32'h9000, 32'h800, 32'h2000, 32'h800, 32'h0, 32'h0);
    src_idle_pct = 0;
    snk_stall_pct = 86;
    random_items(350);
    program_heap(32'h0, 32'h0, 32'h4000, 32'h10, 32'h0, 32'hffff_ffff);
    src_idle_pct = 18;
    snk_stall_pct = 18;
    random_items(40);
    program_heap(32'hffff_fff0, 32'h7, 32'h0, 32'hffff_ffff, 32'h4000, 32'h0);
    random_items(300);
    drain();
    repeat (100) @(posedge clk);
    $display("checked %0d results over six heap layouts and four idling mixes", sb.checked);
    $display("status counts ok %0d zero %0d nofit %0d bad %0d full %0d", sb.status_seen[0],
             sb.status_seen[1], sb.status_seen[2], sb.status_seen[3], sb.status_seen[4]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
